### rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TMPC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TMPC_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TMPC_ASSERT(name, clk, rst_n, prop, msg)
`define TMPC_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

### rtl/tmpc_pkg.sv
// shared constants and types of the triangle min path cost block
// no dependencies
package tmpc_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int VALUE_BITS = 16;
  localparam int IN_W       = 16;
  localparam int COST_W     = 22;
  localparam int CFG_W      = 7;
  localparam int ROW_CELLS  = 2 * MAX_ROWS - 1;
  localparam int ROW_W      = $clog2(MAX_ROWS + 1);
  localparam int CNT_W      = ROW_W + 1;
  localparam int COL_W      = (ROW_CELLS > 1) ? $clog2(ROW_CELLS) : 1;
  localparam int ADDR_W     = COL_W + 1;
  localparam int MEM_DEPTH  = 2 ** ADDR_W;
  localparam int CFG_RESET  = 6;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic             first_row;  // no row above
    logic             v0;         // predecessor at same column valid
    logic             v1;         // predecessor one column left valid
    logic             v2;         // predecessor two columns left valid
    logic             last_row;
    logic             emit;       // last cell of the bottom row
    logic [ADDR_W-1:0] wr_addr;
  } cell_ctl_t;

endpackage

### rtl/tmpc_ram.sv
// generic single write, single read port ram with registered read
// no dependencies
module tmpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tmpc_seq.sv
// row and column sequencer: tracks the position in the triangle,
// issues the row memory read address and the per-cell control; uses tmpc_pkg
module tmpc_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [tmpc_pkg::CFG_W-1:0]    row_count_i,
  output logic [tmpc_pkg::ADDR_W-1:0]   rd_addr_o,
  output tmpc_pkg::cell_ctl_t           ctl_o
);

  logic [tmpc_pkg::ROW_W-1:0] row_q, row_d;
  logic [tmpc_pkg::COL_W-1:0] col_q, col_d;
  logic [tmpc_pkg::ROW_W-1:0] rows;
  logic [tmpc_pkg::CNT_W-1:0] colx, r2, row1;
  logic                       first_row, last_row, row_end;

  // clamp the configured row count into 1..max rows
  always_comb begin
    if (row_count_i == '0) begin
      rows = tmpc_pkg::ROW_W'(1);
    end else if (32'(row_count_i) > 32'(tmpc_pkg::MAX_ROWS)) begin
      rows = tmpc_pkg::ROW_W'(tmpc_pkg::MAX_ROWS);
    end else begin
      rows = tmpc_pkg::ROW_W'(row_count_i);
    end
  end

  assign colx      = tmpc_pkg::CNT_W'(col_q);
  assign r2        = {row_q, 1'b0};
  assign row1      = tmpc_pkg::CNT_W'(row_q) + tmpc_pkg::CNT_W'(1);
  assign first_row = (row_q == '0);
  assign last_row  = (row1 >= tmpc_pkg::CNT_W'(rows));
  assign row_end   = (colx == r2);

  always_comb begin
    ctl_o.first_row = first_row;
    ctl_o.v0        = !first_row && (colx + tmpc_pkg::CNT_W'(1) < r2);
    ctl_o.v1        = !first_row && (colx >= tmpc_pkg::CNT_W'(1)) && (colx < r2);
    ctl_o.v2        = !first_row && (colx >= tmpc_pkg::CNT_W'(2))
                      && (colx < r2 + tmpc_pkg::CNT_W'(1));
    ctl_o.last_row  = last_row;
    ctl_o.emit      = last_row && row_end;
    ctl_o.wr_addr   = {row_q[0], col_q};
  end

  // the row above sits in the other bank
  assign rd_addr_o = {~row_q[0], col_q};

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (acc_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : tmpc_pkg::ROW_W'(row1);
      end else begin
        col_d = col_q + tmpc_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

### rtl/tmpc_cost.sv
// cost stage: window over the row above, min of predecessors, saturating add,
// row memory write back with forwarding, bottom row minimum and result register
// uses tmpc_pkg
module tmpc_cost (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  tmpc_pkg::cell_ctl_t           ctl_i,
  input  logic [tmpc_pkg::IN_W-1:0]     value_i,
  input  logic [tmpc_pkg::ADDR_W-1:0]   rd_addr_i,
  input  logic [tmpc_pkg::COST_W-1:0]   rd_data_i,
  output logic                          we_o,
  output logic [tmpc_pkg::ADDR_W-1:0]   waddr_o,
  output logic [tmpc_pkg::COST_W-1:0]   wdata_o,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tmpc_pkg::COST_W-1:0]   out_data_o
);

  logic                                s1_valid_q;
  tmpc_pkg::cell_ctl_t                 ctl_q;
  logic [tmpc_pkg::VALUE_BITS-1:0]     value_q;
  logic                                fwd_q;
  logic [tmpc_pkg::COST_W-1:0]         fwd_data_q;
  logic [tmpc_pkg::COST_W-1:0]         w1_q, w2_q;
  logic [tmpc_pkg::COST_W-1:0]         bmin_q, bmin_d;
  logic                                out_valid_q;
  logic [tmpc_pkg::COST_W-1:0]         out_data_q;
  logic [tmpc_pkg::COST_W-1:0]         prev_c, m0, m1, m2, m01, best, cost, new_min;
  logic [tmpc_pkg::COST_W:0]           sum;
  logic                                fire;

  assign advance_o = !(s1_valid_q && ctl_q.emit && out_valid_q && !out_ready_i);
  assign fire      = s1_valid_q && advance_o;

  // same-cycle write of the entry being read goes around the ram
  assign prev_c = fwd_q ? fwd_data_q : rd_data_i;

  assign m0   = ctl_q.v0 ? prev_c : tmpc_pkg::COST_MAX;
  assign m1   = ctl_q.v1 ? w1_q : tmpc_pkg::COST_MAX;
  assign m2   = ctl_q.v2 ? w2_q : tmpc_pkg::COST_MAX;
  assign m01  = (m1 < m0) ? m1 : m0;
  assign best = ctl_q.first_row ? '0 : ((m2 < m01) ? m2 : m01);
  assign sum  = (tmpc_pkg::COST_W + 1)'(best) + (tmpc_pkg::COST_W + 1)'(value_q);
  assign cost = sum[tmpc_pkg::COST_W] ? tmpc_pkg::COST_MAX : sum[tmpc_pkg::COST_W-1:0];

  assign new_min = (cost < bmin_q) ? cost : bmin_q;

  assign we_o    = fire;
  assign waddr_o = ctl_q.wr_addr;
  assign wdata_o = cost;

  always_comb begin
    bmin_d = bmin_q;
    if (fire && ctl_q.last_row) begin
      bmin_d = ctl_q.emit ? tmpc_pkg::COST_MAX : new_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bmin_q      <= tmpc_pkg::COST_MAX;
    end else begin
      if (advance_o) begin
        s1_valid_q <= acc_i;
      end
      if (fire && ctl_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      bmin_q <= bmin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      ctl_q      <= ctl_i;
      value_q    <= value_i[tmpc_pkg::VALUE_BITS-1:0];
      fwd_q      <= fire && (ctl_q.wr_addr == rd_addr_i);
      fwd_data_q <= cost;
    end
    if (fire) begin
      w1_q <= prev_c;
      w2_q <= w1_q;
    end
    if (fire && ctl_q.emit) begin
      out_data_q <= new_min;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/triangle_min_path_cost_core.sv
// top level of the triangle min path cost block
// depends on tmpc_pkg, tmpc_ram, tmpc_seq, tmpc_cost and assert_macros.svh
//
// channel   dir  beat contents                    accepted when
// s_axis    in   cell_value, row-major from apex  s_axis_tvalid & s_axis_tready
// m_axis    out  least_cost of one triangle       m_axis_tvalid & m_axis_tready
// cfg       in   row_count                        cfg_valid_i & cfg_ready_o
//
// one cell per cycle unless s_axis stalls; a cell is written back to the row memory from the cost stage register
// the least cost shows on m_axis, from its own register, after the bottom row's last beat fires in the cost stage
// the row above lives in one bank of the row memory, the current row in the other
// reset clears counters and the bottom minimum; the row memory needs no clearing
// s_axis stalls only while a finished result waits and a new one is due
`include "assert_macros.svh"

module triangle_min_path_cost_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_axis_tdata: [15:0] cell_value
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,
  // m_axis_tdata: [21:0] least_cost, [23:22] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,
  // cfg_data_i: [6:0] row_count
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmpc_pkg::CFG_W-1:0]    cfg_data_i
);

  logic [tmpc_pkg::CFG_W-1:0]  row_count_q;
  logic                        acc;
  logic                        advance;
  tmpc_pkg::cell_ctl_t         ctl;
  logic [tmpc_pkg::ADDR_W-1:0] rd_addr, waddr;
  logic [tmpc_pkg::COST_W-1:0] rd_data, wdata, out_data;
  logic                        we;
  logic                        pred_ok;

  // config register, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= tmpc_pkg::CFG_W'(tmpc_pkg::CFG_RESET);
    end else if (cfg_valid_i) begin
      row_count_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = advance;
  assign acc           = s_axis_tvalid && advance;

  // position tracking and read address of the row above
  tmpc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .row_count_i (row_count_q),
    .rd_addr_o   (rd_addr),
    .ctl_o       (ctl)
  );

  // two banks of best costs, bank picked by row parity
  tmpc_ram #(
    .Width (tmpc_pkg::COST_W),
    .Depth (tmpc_pkg::MEM_DEPTH)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (acc),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // cost arithmetic, write back and result register
  tmpc_cost u_cost (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .ctl_i       (ctl),
    .value_i     (s_axis_tdata),
    .rd_addr_i   (rd_addr),
    .rd_data_i   (rd_data),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {2'b00, out_data};

  assign pred_ok = ctl.v0 || ctl.v1 || ctl.v2;

  // input only backs up behind a waiting result
  `TMPC_NEVER(a_no_idle_stall, clk_i, rst_ni, !s_axis_tready && !m_axis_tvalid, "idle stall")
  // a below-apex cell always has at least one predecessor in the row above
  `TMPC_ASSERT(a_pred_exists, clk_i, rst_ni, acc && !ctl.first_row |-> pred_ok, "no predecessor")
  // a result only rises after an accepted beat
  `TMPC_ASSERT(a_res_src, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(acc, 2), "orphan result")

endmodule

### tb/tb_triangle_min_path_cost_core.sv
`timescale 1ns / 100ps
// self-checking testbench of triangle_min_path_cost_core: random-gap cell stream, stalled result
// stream, row count changes between phases; depends on tmpc_pkg and the core rtl
module tb_triangle_min_path_cost_core;
  import tmpc_pkg::*;

  localparam int DRAIN_CYCLES = 8;   // result is registered behind the bottom cell's cost stage
  localparam int RANDOM_CELLS = 1250;
  localparam int REPORT_LIMIT = 10;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;   // [15:0] cell_value
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;         // [21:0] least_cost, [23:22] zero
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i    = '0;   // [6:0] row_count

  triangle_min_path_cost_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // cell values waiting for the driver, least costs waiting for the dut
  logic [IN_W-1:0]   cell_q[$];
  logic [COST_W-1:0] least_cost_q[$];

  // path cost tracker: two banks of row costs, alternating by row parity
  logic [COST_W-1:0] row_cost_bank [2][ROW_CELLS];
  int unsigned       tri_row = 0;
  int unsigned       tri_col = 0;
  logic [COST_W-1:0] bottom_min = COST_MAX;
  logic [CFG_W-1:0]  row_count_reg = CFG_W'(CFG_RESET);

  int unsigned send_wait = 0, send_quiet = 0;
  int unsigned recv_wait = 0, recv_quiet = 0;
  int unsigned cells_accepted = 0, results_checked = 0, cfg_writes = 0;
  int unsigned mismatches = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // zero means one row, anything above the row memory means all rows
  function automatic int unsigned rows_for(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_ROWS) return MAX_ROWS;
    return v;
  endfunction

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int unsigned next_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // extremes and small values give ties between predecessors
  function automatic logic [IN_W-1:0] pick_cell_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 45) return IN_W'($urandom_range(0, 15));
    return IN_W'($urandom);
  endfunction

  // fold one cell into the tracked row costs; queue a least cost after the bottom row
  task automatic fold_cell(input logic [IN_W-1:0] value);
    int unsigned       rows, bank, up_bank, span_above, p, k;
    logic [COST_W-1:0] best;
    logic [COST_W:0]   sum;
    bit                bottom;
    rows    = rows_for(row_count_reg);
    bank    = tri_row & 1;
    up_bank = bank ^ 1;
    bottom  = (tri_row + 1 >= rows);   // also true once a lowered count is passed
    if (tri_row == 0) begin
      sum = {1'b0, COST_W'(value)};
    end else begin
      span_above = 2 * tri_row - 1;
      best = COST_MAX;
      // predecessors sit at the same column and one or two to the left
      for (k = 0; k < 3; k++) begin
        if (tri_col >= k) begin
          p = tri_col - k;
          if (p < span_above && p < ROW_CELLS && row_cost_bank[up_bank][p] < best)
            best = row_cost_bank[up_bank][p];
        end
      end
      sum = {1'b0, best} + value;
    end
    if (sum > COST_MAX) sum = {1'b0, COST_MAX};
    if (tri_col < ROW_CELLS) row_cost_bank[bank][tri_col] = sum[COST_W-1:0];
    if (bottom && sum[COST_W-1:0] < bottom_min) bottom_min = sum[COST_W-1:0];
    if (tri_col + 1 >= 2 * tri_row + 1) begin
      tri_col = 0;
      if (bottom) begin
        least_cost_q.push_back(bottom_min);
        tri_row    = 0;
        bottom_min = COST_MAX;
      end else begin
        tri_row++;
      end
    end else begin
      tri_col++;
    end
  endtask

  // driver: one cell beat per free slot, random gap after each beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        fold_cell(s_axis_tdata);
        cells_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (cell_q.size() > 0) begin
          s_axis_tdata  <= cell_q.pop_front();
          s_axis_tvalid <= 1'b1;
          send_wait = next_gap(send_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest queued least cost
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (least_cost_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result beat: least_cost %0d", m_axis_tdata[COST_W-1:0]);
        end else if (m_axis_tdata !== {2'b00, least_cost_q[0]}) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("least_cost mismatch: expected %0d got %0d (tdata %h)",
                     least_cost_q[0], m_axis_tdata[COST_W-1:0], m_axis_tdata);
          void'(least_cost_q.pop_front());
        end else begin
          void'(least_cost_q.pop_front());
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ((m_axis_tvalid && m_axis_tready) || $urandom_range(0, 7) == 0)
          recv_wait = next_gap(recv_quiet);
      end
    end
  end

  // sender paused: every queued cell sent and every least cost received
  // checked mid-cycle so the driver and monitor updates of the edge are settled
  task automatic wait_idle();
    while (cell_q.size() != 0 || s_axis_tvalid || least_cost_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_row_count(input logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    row_count_reg = v;
    cfg_writes++;
  endtask

  task automatic push_cells(input int unsigned n);
    repeat (n) cell_q.push_back(pick_cell_value());
  endtask

  initial begin
    int unsigned      random_cells, n, rows, r;
    logic [CFG_W-1:0] rc;
    random_cells = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-cell triangles at both value extremes
    write_row_count(1);
    cell_q.push_back('0);
    cell_q.push_back('1);
    wait_idle();
    // count of zero acts as one row
    write_row_count(0);
    cell_q.push_back(16'h5A5A);
    wait_idle();
    // two rows of maximum values
    write_row_count(2);
    repeat (4) cell_q.push_back('1);
    wait_idle();
    // three rows where the cheapest path takes the two-left predecessor
    write_row_count(3);
    cell_q.push_back(16'd1);
    cell_q.push_back(16'd50);
    cell_q.push_back(16'd50);
    cell_q.push_back(16'd0);
    repeat (4) cell_q.push_back(16'd100);
    cell_q.push_back(16'd0);
    wait_idle();
    // count lowered mid-triangle: row 2 becomes the bottom row
    write_row_count(4);
    repeat (4) cell_q.push_back(pick_cell_value());
    wait_idle();
    write_row_count(2);
    repeat (5) cell_q.push_back(pick_cell_value());
    wait_idle();

    // count above the row memory for three rows, then row 3 made the bottom row
    write_row_count(7'd127);
    push_cells(9);
    wait_idle();
    write_row_count(7'd4);
    push_cells(7);
    wait_idle();
    // a larger triangle of maximum values
    write_row_count(7'd24);
    repeat (24 * 24) cell_q.push_back('1);
    wait_idle();

    // random phases, mostly small triangles, some ending mid-triangle
    while (random_cells < RANDOM_CELLS) begin
      r = $urandom_range(0, 99);
      if (r < 5)       rc = '0;
      else if (r < 75) rc = CFG_W'($urandom_range(1, 6));
      else if (r < 95) rc = CFG_W'($urandom_range(7, 16));
      else             rc = CFG_W'($urandom_range(17, 24));
      write_row_count(rc);
      rows = rows_for(rc);
      n = rows * rows * ((rows > 16) ? 1 : $urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, rows * rows);
      push_cells(n);
      random_cells += n;
      wait_idle();
    end

    $display("run covered %0d cell beats and %0d least cost beats over %0d row count writes",
             cells_accepted, results_checked, cfg_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && least_cost_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### triangle_min_path_cost_core.f
+incdir+rtl
rtl/tmpc_pkg.sv
rtl/tmpc_ram.sv
rtl/tmpc_seq.sv
rtl/tmpc_cost.sv
rtl/triangle_min_path_cost_core.sv
tb/tb_triangle_min_path_cost_core.sv
